@@ rtl/bphc_pkg.sv @@
// shared constants, types and the seven-segment table of the button press counter
package bphc_pkg;

  localparam int NUM_BUTTONS = 4;
  localparam int MAX_DIGITS  = 4;
  localparam int PIN_W       = 4;
  localparam int COUNT_W     = 4;
  localparam int SEG_W       = 8;
  localparam int WINDOW_W    = 16;
  localparam int IN_DATA_W   = 8;
  localparam int OUT_DATA_W  = 56;
  localparam int DOT_BIT     = 1;

  localparam logic [WINDOW_W-1:0] WINDOW_RESET = 16'd127;
  localparam logic [PIN_W-1:0]    PIN_MASK     =
      PIN_W'((1 << ((NUM_BUTTONS > PIN_W) ? PIN_W : NUM_BUTTONS)) - 1);

  typedef struct packed {
    logic update;    // settled value changed at window end
    logic fall;      // this button went from released to pressed
    logic released;  // settled level of this button
  } digit_ctl_t;

  // bit map from bit 0: G,H,E,C,D,B,A,F
  function automatic logic [SEG_W-1:0] seg_pattern(input logic [COUNT_W-1:0] value);
    logic [SEG_W-1:0] pat;
    case (value)
      4'h0: pat = 8'hFC;
      4'h1: pat = 8'h28;
      4'h2: pat = 8'h75;
      4'h3: pat = 8'h79;
      4'h4: pat = 8'hA9;
      4'h5: pat = 8'hD9;
      4'h6: pat = 8'hDD;
      4'h7: pat = 8'h68;
      4'h8: pat = 8'hFD;
      4'h9: pat = 8'hF9;
      4'hA: pat = 8'hED;
      4'hB: pat = 8'h9D;
      4'hC: pat = 8'hD4;
      4'hD: pat = 8'h3D;
      4'hE: pat = 8'hD5;
      4'hF: pat = 8'hC5;
      default: pat = 8'hFC;
    endcase
    return pat;
  endfunction

endpackage

@@ rtl/bphc_digit.sv @@
// one button's hex press count and its segment byte
module bphc_digit (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          step,
  input  logic [bphc_pkg::COUNT_W-1:0]  digit_index,
  input  bphc_pkg::digit_ctl_t          ctl,
  output logic [bphc_pkg::COUNT_W-1:0]  count_next,
  output logic [bphc_pkg::SEG_W-1:0]    seg_next
);
  import bphc_pkg::*;

  logic [COUNT_W-1:0] count;
  logic [SEG_W-1:0]   seg;

  always_comb begin
    count_next = count;
    seg_next   = seg;
    if (step && ctl.update) begin
      if (ctl.fall) begin
        count_next = count + 1'b1;
        seg_next   = seg_pattern(count_next);
      end
      seg_next[DOT_BIT] = ctl.released;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      seg   <= seg_pattern(digit_index);
    end else begin
      count <= count_next;
      seg   <= seg_next;
    end
  end

endmodule

@@ rtl/button_press_hex_counter_display.sv @@
// button press counter: sample window debounce, per-button hex counts and segment bytes
//
// Input stream s_axis carries one raw button sample per transaction
// (bit i = button i, 1 released, 0 pressed). Each sample is ANDed into the
// current window; after sample_window samples (0 acts as 1) the window
// closes and its AND becomes the settled value. A changed settled value
// advances the count of every button that went from released to pressed,
// reloads that digit's segment byte, and sets each dot from its button.
// Every sample yields exactly one result transaction on m_axis with all
// four segment bytes and counts; tuser flags the samples that closed a window.
// The result is valid in the cycle after the input transaction, and while
// the receiver keeps up the block takes one sample per cycle: the single
// result register is refilled in the same cycle it is drained. When the
// receiver stalls, it holds and s_axis_tready drops until it is taken.
// cfg_* writes sample_window (reset 127); it is always ready and should only
// be written while no sample is in flight. Synchronous reset clears the
// window, counts and settled value, loads digits with the patterns of 0..3
// and empties the result register.
module button_press_hex_counter_display (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [bphc_pkg::WINDOW_W-1:0]     cfg_data,       // sample_window
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [bphc_pkg::IN_DATA_W-1:0]    s_axis_tdata,   // button_pins, zero pad
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // settled_buttons, segments_digit0..3, press_count0..3, zero pad
  output logic [bphc_pkg::OUT_DATA_W-1:0]   m_axis_tdata,
  output logic                              m_axis_tuser    // window_end
);
  import bphc_pkg::*;

  logic [WINDOW_W-1:0] sample_window;
  logic [PIN_W-1:0]    window_and;
  logic [WINDOW_W-1:0] window_samples;
  logic [PIN_W-1:0]    previous_settled;

  logic                step;
  logic [PIN_W-1:0]    pins;
  logic [WINDOW_W-1:0] limit;
  logic [WINDOW_W:0]   taken;
  logic                ended;
  logic [PIN_W-1:0]    and_next;
  logic                changed;

  logic [COUNT_W-1:0]  count_next [MAX_DIGITS];
  logic [SEG_W-1:0]    seg_next   [MAX_DIGITS];

  logic [PIN_W-1:0]    out_settled;
  logic [SEG_W-1:0]    out_seg   [MAX_DIGITS];
  logic [COUNT_W-1:0]  out_count [MAX_DIGITS];
  logic                out_end;
  logic                out_valid;

  assign cfg_ready     = 1'b1;
  assign s_axis_tready = !out_valid || m_axis_tready;
  assign step          = s_axis_tvalid && s_axis_tready;

  assign pins     = s_axis_tdata[PIN_W-1:0] & PIN_MASK;
  assign limit    = (sample_window == '0) ? WINDOW_W'(1) : sample_window;
  assign taken    = {1'b0, window_samples} + 1'b1;
  assign ended    = taken >= {1'b0, limit};
  assign and_next = window_and & pins;
  assign changed  = ended && (and_next != previous_settled);

  always_ff @(posedge clk) begin
    if (rst) begin
      sample_window <= WINDOW_RESET;
    end else if (cfg_valid && cfg_ready) begin
      sample_window <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      window_and       <= '1;
      window_samples   <= '0;
      previous_settled <= '0;
    end else if (step) begin
      if (ended) begin
        window_and     <= '1;
        window_samples <= '0;
        if (changed) begin
          previous_settled <= and_next;
        end
      end else begin
        window_and     <= and_next;
        window_samples <= taken[WINDOW_W-1:0];
      end
    end
  end

  for (genvar i = 0; i < MAX_DIGITS; i++) begin : g_digit
    if (i < NUM_BUTTONS) begin : g_live
      digit_ctl_t ctl;
      assign ctl.update   = changed;
      assign ctl.fall     = previous_settled[i] && !and_next[i];
      assign ctl.released = and_next[i];
      bphc_digit u_digit (
        .clk         (clk),
        .rst         (rst),
        .step        (step),
        .digit_index (COUNT_W'(i)),
        .ctl         (ctl),
        .count_next  (count_next[i]),
        .seg_next    (seg_next[i])
      );
    end else begin : g_absent
      assign count_next[i] = '0;
      assign seg_next[i]   = '0;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (step) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      out_end     <= ended;
      out_settled <= changed ? and_next : previous_settled;
      out_seg     <= seg_next;
      out_count   <= count_next;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tuser  = out_end;
  assign m_axis_tdata  = {4'b0000,
                          out_count[3], out_count[2], out_count[1], out_count[0],
                          out_seg[3], out_seg[2], out_seg[1], out_seg[0],
                          out_settled};

endmodule
